// ----- rtl/core/bws_pkg.sv -----
// shared types and constants of the bilinear warp sampler
package bws_pkg;

  localparam int SRC_ROWS    = 1024;
  localparam int SRC_COLS    = 1024;
  localparam int RW          = (SRC_ROWS > 2) ? $clog2(SRC_ROWS) : 2;
  localparam int CW          = (SRC_COLS > 2) ? $clog2(SRC_COLS) : 2;
  localparam int BANK_AW     = RW - 1 + CW - 1;
  localparam int BANK_DEPTH  = 2 ** BANK_AW;
  localparam int CRD_W       = 13;
  localparam int COEF_W      = 48;
  localparam int NUM_COEF    = 8;
  localparam int CFG_IDX_W   = 4;
  localparam int UV_W        = 20;
  localparam int PT_W        = 70;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [COEF_W-1:0] ONE_Q32 = 48'h0001_0000_0000;

  typedef enum logic [2:0] {
    CFG_X_UV    = 3'd0,
    CFG_X_U     = 3'd1,
    CFG_X_V     = 3'd2,
    CFG_X_CONST = 3'd3,
    CFG_Y_UV    = 3'd4,
    CFG_Y_U     = 3'd5,
    CFG_Y_V     = 3'd6,
    CFG_Y_CONST = 3'd7
  } cfg_idx_e;

  typedef enum logic {
    MODE_WRITE  = 1'b0,
    MODE_SAMPLE = 1'b1
  } mode_e;

  typedef logic [NUM_COEF-1:0][COEF_W-1:0] coef_arr_t;

  // identity mapping: x gain on u and y gain on v are one
  localparam coef_arr_t COEF_RESET = {
    {COEF_W{1'b0}}, ONE_Q32, {(4*COEF_W){1'b0}}, ONE_Q32, {COEF_W{1'b0}}
  };

  typedef struct packed {
    mode_e            mode;
    logic [9:0]       row;
    logic [9:0]       col;
    logic [7:0]       pix;
    logic [UV_W-1:0]  uv;
  } item_t;

endpackage

// ----- rtl/core/bilinear_warp_sampler_top.sv -----
// path: an input transaction passes the input register, the queue and the mapping,
// image store and interpolation pipeline before its result is shown
// throughput: one item per cycle; the four parity banks of the image store give all
// four neighbors in one access; a held-off result stalls the pipeline, the queue absorbs two
// writes give no result; samples give one result each
// reset clears control state and sets the mapping to identity; image contents
// are undefined until written
module bilinear_warp_sampler_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bws_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bws_pkg::COEF_W-1:0]    cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [31:0]                   s_axis_tdata,  // row, col, pixel_in
  input  logic [0:0]                    s_axis_tuser,  // mode
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,  // pixel_out
  output logic [0:0]                    m_axis_tuser   // out_of_range
);
  import bws_pkg::*;

  coef_arr_t coef_q;
  logic      push_valid, push_ready, pop_valid, pop_ready;
  item_t     push_item, pop_item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= COEF_RESET;
    end else if (cfg_valid_i && !cfg_index_i[CFG_IDX_W-1]) begin
      coef_q[cfg_index_i[CFG_IDX_W-2:0]] <= cfg_data_i;
    end
  end

  bws_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_item_o   (push_item)
  );

  bws_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (push_valid),
    .in_ready_o  (push_ready),
    .in_item_i   (push_item),
    .out_valid_o (pop_valid),
    .out_ready_i (pop_ready),
    .out_item_o  (pop_item)
  );

  bws_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .coef_i        (coef_q),
    .item_valid_i  (pop_valid),
    .item_ready_o  (pop_ready),
    .item_i        (pop_item),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ----- rtl/core/bws_ram.sv -----
// generic simple dual-port ram with registered read
module bws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/bws_front.sv -----
// input stage: accepts items, registers them and forms u*v
module bws_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  input  logic [31:0]    s_axis_tdata,
  input  logic [0:0]     s_axis_tuser,
  output logic           push_valid_o,
  input  logic           push_ready_i,
  output bws_pkg::item_t push_item_o
);
  import bws_pkg::*;

  logic  vld_q, vld_d;
  item_t item_q;
  logic  accept;

  assign s_axis_tready = !vld_q || push_ready_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (push_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.mode <= mode_e'(s_axis_tuser[0]);
      item_q.row  <= s_axis_tdata[9:0];
      item_q.col  <= s_axis_tdata[19:10];
      item_q.pix  <= s_axis_tdata[27:20];
      item_q.uv   <= UV_W'(s_axis_tdata[19:10]) * UV_W'(s_axis_tdata[9:0]);
    end
  end

  assign push_valid_o = vld_q;
  assign push_item_o  = item_q;

endmodule

// ----- rtl/core/bws_queue.sv -----
// short fifo between front and back
module bws_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  bws_pkg::item_t in_item_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output bws_pkg::item_t out_item_o
);
  import bws_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  item_t         mem_q [QUEUE_DEPTH];
  logic [PW-1:0] wp_q, rp_q;
  logic [NW-1:0] cnt_q;
  logic          push, pop;

  assign in_ready_o  = cnt_q != NW'(QUEUE_DEPTH);
  assign out_valid_o = cnt_q != '0;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_item_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wp_q <= (wp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
      end
      if (pop) begin
        rp_q <= (rp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
      end
      cnt_q <= cnt_q + NW'(push) - NW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= in_item_i;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= NW'(QUEUE_DEPTH)) else $error("queue count overflow");
  a_push_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> out_valid_o) else $error("pushed entry lost");
`endif

endmodule

// ----- rtl/core/bws_back.sv -----
// mapping, image store access and interpolation pipeline
module bws_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bws_pkg::coef_arr_t  coef_i,
  input  logic                item_valid_i,
  output logic                item_ready_o,
  input  bws_pkg::item_t      item_i,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,
  output logic [0:0]          m_axis_tuser
);
  import bws_pkg::*;

  logic        adv;
  logic [5:0]  vld_q;
  mode_e       mode_q [6];
  logic [9:0]  row_q [4];
  logic [9:0]  col_q [4];
  logic [7:0]  pix_q [4];

  logic [43:0]        lo_d [2][3], lo_q [2][3];
  logic signed [44:0] hi_d [2][3], hi_q [2][3];
  logic signed [PT_W-1:0] term_d [2][3], term_q [2][3];
  logic signed [PT_W-1:0] pt_d [2], pt_q [2];

  logic [CW-1:0] fx_d, fx1_d, fx_q, fx1_q;
  logic [RW-1:0] fy_d, fy1_d, fy_q, fy1_q;
  logic [7:0]    w_d, h_d, w4_q, h4_q, w5_q, h5_q, h6_q;
  logic          flag_d, flag4_q, flag5_q, flag6_q;
  logic [3:0]    par5_q;

  logic [CRD_W-1:0]   wrow, wcol;
  logic               in_img;
  logic [BANK_AW-1:0] waddr;
  logic [BANK_AW-1:0] raddr [4];
  logic [3:0]         ram_we;
  logic [7:0]         rdata [4];

  logic [15:0] ab_d, cd_d, ab_q, cd_q;
  logic [23:0] acc;
  logic        out_vld_q;
  logic [7:0]  out_pix_q;
  logic        out_flag_q;

  assign adv          = !out_vld_q || m_axis_tready;
  assign item_ready_o = adv;

  // coefficient products split into two halves of the coefficient
  always_comb begin
    logic [COEF_W-1:0] c;
    logic [UV_W-1:0]   m;
    for (int a = 0; a < 2; a++) begin
      for (int t = 0; t < 3; t++) begin
        c = coef_i[a*4+t];
        if (t == 0) begin
          m = item_i.uv;
        end else if (t == 1) begin
          m = UV_W'(item_i.col);
        end else begin
          m = UV_W'(item_i.row);
        end
        lo_d[a][t] = 44'(c[23:0]) * 44'(m);
        hi_d[a][t] = 45'($signed(c[47:24])) * 45'($signed({1'b0, m}));
      end
    end
  end

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      for (int t = 0; t < 3; t++) begin
        term_d[a][t] = (PT_W'(hi_q[a][t]) <<< 24) + $signed(PT_W'(lo_q[a][t]));
      end
      pt_d[a] = term_q[a][0] + term_q[a][1] + term_q[a][2]
              + PT_W'($signed(coef_i[a*4+3]));
    end
  end

  // split into clamped index and q8 weight
  always_comb begin
    logic [37:0] ipx, ipy;
    logic        negx, negy, bigx, bigy;
    ipx  = pt_q[0][PT_W-1:32];
    ipy  = pt_q[1][PT_W-1:32];
    negx = pt_q[0][PT_W-1];
    negy = pt_q[1][PT_W-1];
    bigx = ipx > 38'(SRC_COLS - 1);
    bigy = ipy > 38'(SRC_ROWS - 1);
    if (negx) begin
      fx_d = '0;
    end else if (bigx) begin
      fx_d = CW'(SRC_COLS - 1);
    end else begin
      fx_d = ipx[CW-1:0];
    end
    if (negy) begin
      fy_d = '0;
    end else if (bigy) begin
      fy_d = RW'(SRC_ROWS - 1);
    end else begin
      fy_d = ipy[RW-1:0];
    end
    w_d    = (negx || bigx) ? 8'd0 : pt_q[0][31:24];
    h_d    = (negy || bigy) ? 8'd0 : pt_q[1][31:24];
    fx1_d  = (fx_d == CW'(SRC_COLS - 1)) ? fx_d : fx_d + 1'b1;
    fy1_d  = (fy_d == RW'(SRC_ROWS - 1)) ? fy_d : fy_d + 1'b1;
    flag_d = negx || bigx || negy || bigy;
  end

  // four banks by row and column parity
  always_comb begin
    logic [RW-1:0] rsel;
    logic [CW-1:0] csel;
    wrow   = CRD_W'(row_q[3]);
    wcol   = CRD_W'(col_q[3]);
    in_img = (wrow < CRD_W'(SRC_ROWS)) && (wcol < CRD_W'(SRC_COLS));
    waddr  = {wrow[RW-1:1], wcol[CW-1:1]};
    for (int b = 0; b < 4; b++) begin
      rsel = (fy_q[0] == b[1]) ? fy_q : fy1_q;
      csel = (fx_q[0] == b[0]) ? fx_q : fx1_q;
      raddr[b]  = {rsel[RW-1:1], csel[CW-1:1]};
      ram_we[b] = adv && vld_q[3] && (mode_q[3] == MODE_WRITE) && in_img
               && (wrow[0] == b[1]) && (wcol[0] == b[0]);
    end
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    bws_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_ram (
      .clk_i   (clk_i),
      .we_i    (ram_we[b]),
      .waddr_i (waddr),
      .wdata_i (pix_q[3]),
      .re_i    (adv),
      .raddr_i (raddr[b]),
      .rdata_o (rdata[b])
    );
  end

  always_comb begin
    logic [7:0] pa, pb, pc, pd;
    logic [8:0] wi;
    pa   = rdata[{par5_q[2], par5_q[0]}];
    pb   = rdata[{par5_q[2], par5_q[1]}];
    pc   = rdata[{par5_q[3], par5_q[0]}];
    pd   = rdata[{par5_q[3], par5_q[1]}];
    wi   = 9'd256 - {1'b0, w5_q};
    ab_d = 16'(pa) * 16'(wi) + 16'(pb) * 16'(w5_q);
    cd_d = 16'(pc) * 16'(wi) + 16'(pd) * 16'(w5_q);
  end

  assign acc = 24'(ab_q) * 24'(9'd256 - {1'b0, h6_q}) + 24'(cd_q) * 24'(h6_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[4:0], item_valid_i};
      out_vld_q <= vld_q[5] && (mode_q[5] == MODE_SAMPLE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mode_q[0] <= item_i.mode;
      row_q[0]  <= item_i.row;
      col_q[0]  <= item_i.col;
      pix_q[0]  <= item_i.pix;
      for (int k = 1; k < 6; k++) begin
        mode_q[k] <= mode_q[k-1];
      end
      for (int k = 1; k < 4; k++) begin
        row_q[k] <= row_q[k-1];
        col_q[k] <= col_q[k-1];
        pix_q[k] <= pix_q[k-1];
      end
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      term_q  <= term_d;
      pt_q    <= pt_d;
      fx_q    <= fx_d;
      fx1_q   <= fx1_d;
      fy_q    <= fy_d;
      fy1_q   <= fy1_d;
      w4_q    <= w_d;
      h4_q    <= h_d;
      flag4_q <= flag_d;
      w5_q    <= w4_q;
      h5_q    <= h4_q;
      flag5_q <= flag4_q;
      par5_q  <= {fy1_q[0], fy_q[0], fx1_q[0], fx_q[0]};
      ab_q    <= ab_d;
      cd_q    <= cd_d;
      h6_q    <= h5_q;
      flag6_q <= flag5_q;
      out_pix_q  <= acc[23:16];
      out_flag_q <= flag6_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_pix_q;
  assign m_axis_tuser  = out_flag_q;

`ifndef SYNTHESIS
  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q)) else $error("pipeline moved during stall");
  a_sample_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && vld_q[5] && (mode_q[5] == MODE_SAMPLE) |=> m_axis_tvalid)
    else $error("sample result dropped");
`endif

endmodule
